[hw/rtl/cpp_pkg.sv]
// shared types, constants and command/status structs of the coastline point projector
package cpp_pkg;

	localparam int COORD_BITS     = 16;
	localparam int TRIG_BITS      = 16;
	localparam int TRIG_FRAC_BITS = 15;
	localparam int OUT_BITS       = 16;
	localparam int ROT_BITS       = COORD_BITS + 2;
	localparam int PROD_BITS      = TRIG_BITS + ROT_BITS;
	localparam int SUM_BITS       = PROD_BITS + 1;
	localparam int CFG_IDX_BITS   = 3;
	localparam int CFG_DATA_BITS  = 16;
	localparam int STEP_BITS      = 8;
	localparam int SEQ_BITS       = 4;
	localparam int SEQ_LAST       = 8;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [ROT_BITS-1:0]   rot_t;
	typedef logic signed [TRIG_BITS-1:0]  trig_t;
	typedef logic signed [PROD_BITS-1:0]  prod_t;
	typedef logic signed [SUM_BITS-1:0]   sum_t;
	typedef logic signed [OUT_BITS-1:0]   scr_t;

	typedef struct packed {
		logic signed [15:0] delta_x;
		logic signed [15:0] delta_y;
		logic signed [15:0] delta_z;
		logic               curve_start;
		logic               curve_end;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] screen_x;
		logic signed [15:0] screen_y;
		logic               visible;
		logic               run_start;
		logic               is_closure;
		logic               last_result;
	} out_item_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_COS_PHI    = 3'd0,
		REG_SIN_PHI    = 3'd1,
		REG_COS_THETA  = 3'd2,
		REG_SIN_THETA  = 3'd3,
		REG_HIDE_EN    = 3'd4,
		REG_DECIM_STEP = 3'd5
	} cfg_reg_t;

	// trig coefficient and operand pair fed to the shared multiplier
	typedef enum logic [2:0] {
		MUL_CP_X,
		MUL_SP_Z,
		MUL_CP_Z,
		MUL_SP_X,
		MUL_ST_Y,
		MUL_CT_Z1,
		MUL_CT_Y,
		MUL_ST_Z1
	} mul_op_t;

	typedef enum logic [2:0] {
		DST_NONE,
		DST_X1,
		DST_Z1,
		DST_Z2,
		DST_Y2
	} rot_dst_t;

	typedef struct packed {
		logic     accept;
		mul_op_t  mul_op;
		logic     t_load;
		rot_dst_t dst;
		logic     sub;
		logic     load_pt;
		logic     load_cl;
	} cpp_cmd_t;

	typedef struct packed {
		logic kept_now;
		logic close_now;
		logic close_pend;
		logic out_free;
	} cpp_status_t;

endpackage

[hw/rtl/cpp_datapath.sv]
// datapath: config registers, accumulators, shared rotation multiplier and output register
module cpp_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [cpp_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [cpp_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	input  cpp_pkg::in_item_t                  in_data,
	input  logic                               out_stall,
	output logic                               out_valid,
	output cpp_pkg::out_item_t                 out_data,
	input  cpp_pkg::cpp_cmd_t                  cmd,
	output cpp_pkg::cpp_status_t               status
);
	import cpp_pkg::*;

	localparam rot_t SAT_HI = rot_t'((2 ** (OUT_BITS - 1)) - 1);
	localparam rot_t SAT_LO = rot_t'(-(2 ** (OUT_BITS - 1)));
	localparam sum_t RND_HALF = sum_t'(2 ** (TRIG_FRAC_BITS - 1));

	function automatic scr_t sat_out(input rot_t v);
		scr_t r;
		if (v > SAT_HI) begin
			r = scr_t'(SAT_HI);
		end else if (v < SAT_LO) begin
			r = scr_t'(SAT_LO);
		end else begin
			r = scr_t'(v);
		end
		return r;
	endfunction

	trig_t cos_phi_q, sin_phi_q, cos_theta_q, sin_theta_q;
	logic hide_en_q;
	logic [STEP_BITS-1:0] decim_q;

	coord_t acc_x_q, acc_y_q, acc_z_q;
	logic [STEP_BITS-1:0] skip_q;
	logic run_open_q, fp_valid_q, end_q, close_q;
	scr_t fp_x_q, fp_y_q;

	trig_t mul_a;
	rot_t mul_b;
	prod_t prod_q, t_q;
	rot_t x1_q, z1_q, z2_q, y2_q;
	sum_t sum, rsum;
	rot_t rot_val;

	logic out_valid_q;
	out_item_t out_q;

	logic [STEP_BITS-1:0] skip_eff, step_eff, skip_next;
	logic [STEP_BITS:0] skip_inc;
	logic kept_now, close_now, fp_eff;
	coord_t base_x, base_y, base_z;
	scr_t pt_x, pt_y;
	logic pt_vis;
	logic out_free;

	// curve bookkeeping seen by an arriving request
	always_comb begin
		skip_eff  = in_data.curve_start ? '0 : skip_q;
		fp_eff    = in_data.curve_start ? 1'b0 : fp_valid_q;
		step_eff  = (decim_q == '0) ? STEP_BITS'(1) : decim_q;
		skip_inc  = {1'b0, skip_eff} + (STEP_BITS + 1)'(1);
		skip_next = (skip_inc >= {1'b0, step_eff}) ? '0 : skip_inc[STEP_BITS-1:0];
		kept_now  = (skip_eff == '0);
		close_now = in_data.curve_end && !hide_en_q && (fp_eff || kept_now);
		base_x    = in_data.curve_start ? '0 : acc_x_q;
		base_y    = in_data.curve_start ? '0 : acc_y_q;
		base_z    = in_data.curve_start ? '0 : acc_z_q;
	end

	// multiplier operand select
	always_comb begin
		case (cmd.mul_op)
			MUL_CP_X:  begin mul_a = cos_phi_q;   mul_b = rot_t'(acc_x_q); end
			MUL_SP_Z:  begin mul_a = sin_phi_q;   mul_b = rot_t'(acc_z_q); end
			MUL_CP_Z:  begin mul_a = cos_phi_q;   mul_b = rot_t'(acc_z_q); end
			MUL_SP_X:  begin mul_a = sin_phi_q;   mul_b = rot_t'(acc_x_q); end
			MUL_ST_Y:  begin mul_a = sin_theta_q; mul_b = rot_t'(acc_y_q); end
			MUL_CT_Z1: begin mul_a = cos_theta_q; mul_b = z1_q;            end
			MUL_CT_Y:  begin mul_a = cos_theta_q; mul_b = rot_t'(acc_y_q); end
			MUL_ST_Z1: begin mul_a = sin_theta_q; mul_b = z1_q;            end
			default:   begin mul_a = cos_phi_q;   mul_b = rot_t'(acc_x_q); end
		endcase
	end

	// sum or difference of two products, rounded half up
	always_comb begin
		sum     = cmd.sub ? (sum_t'(t_q) - sum_t'(prod_q)) : (sum_t'(t_q) + sum_t'(prod_q));
		rsum    = (sum + RND_HALF) >>> TRIG_FRAC_BITS;
		rot_val = rot_t'(rsum);
	end

	always_comb begin
		pt_x     = sat_out(x1_q);
		pt_y     = sat_out(y2_q);
		pt_vis   = !(hide_en_q && (z2_q <= rot_t'(0)));
		out_free = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk) begin
		prod_q <= prod_t'(mul_a) * prod_t'(mul_b);
		if (cmd.t_load) begin
			t_q <= prod_q;
		end
		case (cmd.dst)
			DST_X1:  x1_q <= rot_val;
			DST_Z1:  z1_q <= rot_val;
			DST_Z2:  z2_q <= rot_val;
			DST_Y2:  y2_q <= rot_val;
			default: ;
		endcase
		if (cmd.load_pt && !fp_valid_q) begin
			fp_x_q <= pt_x;
			fp_y_q <= pt_y;
		end
		if (cmd.load_pt) begin
			out_q.screen_x    <= pt_x;
			out_q.screen_y    <= pt_y;
			out_q.visible     <= pt_vis;
			out_q.run_start   <= pt_vis && !run_open_q;
			out_q.is_closure  <= 1'b0;
			out_q.last_result <= !close_q;
		end else if (cmd.load_cl) begin
			out_q.screen_x    <= fp_x_q;
			out_q.screen_y    <= fp_y_q;
			out_q.visible     <= 1'b1;
			out_q.run_start   <= 1'b0;
			out_q.is_closure  <= 1'b1;
			out_q.last_result <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_phi_q   <= trig_t'(32767);
			sin_phi_q   <= '0;
			cos_theta_q <= trig_t'(30048);
			sin_theta_q <= trig_t'(13066);
			hide_en_q   <= 1'b1;
			decim_q     <= STEP_BITS'(1);
			acc_x_q     <= '0;
			acc_y_q     <= '0;
			acc_z_q     <= '0;
			skip_q      <= '0;
			run_open_q  <= 1'b0;
			fp_valid_q  <= 1'b0;
			end_q       <= 1'b0;
			close_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_COS_PHI:    cos_phi_q   <= trig_t'(cfg_wdata);
					REG_SIN_PHI:    sin_phi_q   <= trig_t'(cfg_wdata);
					REG_COS_THETA:  cos_theta_q <= trig_t'(cfg_wdata);
					REG_SIN_THETA:  sin_theta_q <= trig_t'(cfg_wdata);
					REG_HIDE_EN:    hide_en_q   <= cfg_wdata[0];
					REG_DECIM_STEP: decim_q     <= cfg_wdata[STEP_BITS-1:0];
					default:        ;
				endcase
			end
			if (cmd.accept) begin
				acc_x_q <= base_x + coord_t'(in_data.delta_x);
				acc_y_q <= base_y + coord_t'(in_data.delta_y);
				acc_z_q <= base_z + coord_t'(in_data.delta_z);
				skip_q  <= in_data.curve_end ? '0 : skip_next;
				end_q   <= in_data.curve_end;
				close_q <= close_now;
				if (in_data.curve_start ||
				    (in_data.curve_end && !kept_now && !close_now)) begin
					run_open_q <= 1'b0;
					fp_valid_q <= 1'b0;
				end
			end
			if (cmd.load_pt) begin
				run_open_q <= end_q ? 1'b0 : pt_vis;
				if (end_q && !close_q) begin
					fp_valid_q <= 1'b0;
				end else begin
					fp_valid_q <= 1'b1;
				end
			end
			if (cmd.load_cl) begin
				run_open_q <= 1'b0;
				fp_valid_q <= 1'b0;
			end
			if (cmd.load_pt || cmd.load_cl) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.kept_now   = kept_now;
	assign status.close_now  = close_now;
	assign status.close_pend = close_q;
	assign status.out_free   = out_free;
	assign out_valid         = out_valid_q;
	assign out_data          = out_q;

endmodule

[hw/rtl/cpp_ctrl.sv]
// controller: sequences accumulation, the nine rotation steps and result emission
module cpp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  cpp_pkg::cpp_status_t status,
	output cpp_pkg::cpp_cmd_t    cmd
);
	import cpp_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROT,
		ST_EMIT_PT,
		ST_EMIT_CL
	} state_t;

	state_t state_q;
	logic [SEQ_BITS-1:0] seq_q;
	logic accept;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seq_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					seq_q <= '0;
					if (accept) begin
						if (status.kept_now) begin
							state_q <= ST_ROT;
						end else if (status.close_now) begin
							state_q <= ST_EMIT_CL;
						end
					end
				end
				ST_ROT: begin
					seq_q <= seq_q + SEQ_BITS'(1);
					if (seq_q == SEQ_BITS'(SEQ_LAST)) begin
						state_q <= ST_EMIT_PT;
					end
				end
				ST_EMIT_PT: begin
					if (status.out_free) begin
						state_q <= status.close_pend ? ST_EMIT_CL : ST_IDLE;
					end
				end
				ST_EMIT_CL: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// rotation schedule: product issue, first-term hold and rounded store
	always_comb begin
		cmd         = '0;
		cmd.mul_op  = MUL_CP_X;
		cmd.dst     = DST_NONE;
		cmd.accept  = accept;
		cmd.load_pt = (state_q == ST_EMIT_PT) && status.out_free;
		cmd.load_cl = (state_q == ST_EMIT_CL) && status.out_free;
		if (state_q == ST_ROT) begin
			unique case (seq_q)
				4'd0: cmd.mul_op = MUL_CP_X;
				4'd1: begin cmd.mul_op = MUL_SP_Z; cmd.t_load = 1'b1; end
				4'd2: begin cmd.mul_op = MUL_CP_Z; cmd.dst = DST_X1; end
				4'd3: begin cmd.mul_op = MUL_SP_X; cmd.t_load = 1'b1; end
				4'd4: begin cmd.mul_op = MUL_ST_Y; cmd.dst = DST_Z1; cmd.sub = 1'b1; end
				4'd5: begin cmd.mul_op = MUL_CT_Z1; cmd.t_load = 1'b1; end
				4'd6: begin cmd.mul_op = MUL_CT_Y; cmd.dst = DST_Z2; end
				4'd7: begin cmd.mul_op = MUL_ST_Z1; cmd.t_load = 1'b1; end
				4'd8: begin cmd.dst = DST_Y2; cmd.sub = 1'b1; end
				default: ;
			endcase
		end
	end

endmodule

[hw/rtl/coastline_point_projector_unit.sv]
// top level of the coastline point projector: controller plus datapath
//
// usage
// - input channel (in_valid / in_stall / in_data) carries one delta-coded point per request;
//   curve_start clears the curve state before the add, curve_end closes the curve
// - output channel (out_valid / out_stall / out_data) carries projected points, 0..2
//   results per request, last_result marking the final one of a request
// - config port: cfg_wr_en with cfg_index / cfg_wdata writes one register per clock;
//   the user must write only while the block is idle; the block itself does not enforce it
// - sequence: a dropped (decimated) point is accepted and the block stays idle; a kept point
//   goes through accept, 9 steps of the single shared 16x18 multiplier, result load, back to idle,
//   plus a closure result load if one is due; a closure-only request is accept, then closure load
// - in_stall stays high until the last result of a request is loaded; the rate is set by the shared multiplier
// - output is a single register: while out_stall is high the result holds and the
//   controller waits in its emit state with in_stall high
// - reset (arst_n low) clears accumulators and curve state, loads the default
//   rotation, hiding on and decimation of one
module coastline_point_projector_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [cpp_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [cpp_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  cpp_pkg::in_item_t                  in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output cpp_pkg::out_item_t                 out_data
);
	import cpp_pkg::*;

	// command and status between controller and datapath
	cpp_cmd_t    cmd;
	cpp_status_t status;

	// sequencer: idle, rotate, emit point, emit closure
	cpp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// accumulators, registers, rotation arithmetic and output register
	cpp_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// testbench of the coastline point projector: predicting checker, request driver, result sink
module tb;
	import cpp_pkg::*;

class projection_checker;
	// register copies
	trig_t      cos_phi, sin_phi, cos_theta, sin_theta;
	bit         hide_on;
	bit [7:0]   decim;
	// curve state copies
	coord_t     acc_x, acc_y, acc_z;
	bit [7:0]   skip_pos;
	bit         run_open;
	scr_t       first_x, first_y;
	bit         first_valid;
	out_item_t  pending_points[$];
	int         mismatch_count;

	function new();
		cos_phi = 16'sd32767;
		sin_phi = 16'sd0;
		cos_theta = 16'sd30048;
		sin_theta = 16'sd13066;
		hide_on = 1'b1;
		decim = 8'd1;
		acc_x = '0;
		acc_y = '0;
		acc_z = '0;
		skip_pos = '0;
		run_open = 1'b0;
		first_x = '0;
		first_y = '0;
		first_valid = 1'b0;
		mismatch_count = 0;
	endfunction

	function void write_reg(cfg_reg_t idx, logic [15:0] val);
		case (idx)
			REG_COS_PHI:    cos_phi = val;
			REG_SIN_PHI:    sin_phi = val;
			REG_COS_THETA:  cos_theta = val;
			REG_SIN_THETA:  sin_theta = val;
			REG_HIDE_EN:    hide_on = val[0];
			REG_DECIM_STEP: decim = val[7:0];
			default: ;
		endcase
	endfunction

	// q1.15 product back to integer, half rounds up
	function longint q_round(longint v);
		return (v + (longint'(1) << (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
	endfunction

	function scr_t clamp16(longint v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	function void note_request(in_item_t req);
		longint      x, y, z, x1, z1, z2, y2, cp, sp, ct, st;
		int unsigned period;
		out_item_t   res[$];
		out_item_t   r;
		period = (decim == 0) ? 1 : decim;
		if (req.curve_start) begin
			acc_x = '0;
			acc_y = '0;
			acc_z = '0;
			skip_pos = '0;
			run_open = 1'b0;
			first_valid = 1'b0;
		end
		acc_x = acc_x + req.delta_x;
		acc_y = acc_y + req.delta_y;
		acc_z = acc_z + req.delta_z;
		if (skip_pos == 0) begin
			x = longint'(acc_x);
			y = longint'(acc_y);
			z = longint'(acc_z);
			cp = longint'(cos_phi);
			sp = longint'(sin_phi);
			ct = longint'(cos_theta);
			st = longint'(sin_theta);
			x1 = q_round(cp * x + sp * z);
			z1 = q_round(cp * z - sp * x);
			z2 = q_round(ct * z1 + st * y);
			y2 = q_round(ct * y - st * z1);
			r.screen_x = clamp16(x1);
			r.screen_y = clamp16(y2);
			r.is_closure = 1'b0;
			r.last_result = 1'b0;
			if (hide_on && z2 <= 0) begin
				r.visible = 1'b0;
				r.run_start = 1'b0;
				run_open = 1'b0;
			end else begin
				r.visible = 1'b1;
				r.run_start = !run_open;
				run_open = 1'b1;
			end
			res.push_back(r);
			if (!first_valid) begin
				first_x = r.screen_x;
				first_y = r.screen_y;
				first_valid = 1'b1;
			end
		end
		skip_pos = (int'(skip_pos) + 1 >= period) ? 8'd0 : skip_pos + 8'd1;
		if (req.curve_end) begin
			if (!hide_on && first_valid) begin
				r.screen_x = first_x;
				r.screen_y = first_y;
				r.visible = 1'b1;
				r.run_start = 1'b0;
				r.is_closure = 1'b1;
				r.last_result = 1'b0;
				res.push_back(r);
			end
			run_open = 1'b0;
			first_valid = 1'b0;
			skip_pos = '0;
		end
		foreach (res[i]) begin
			r = res[i];
			r.last_result = (i == res.size() - 1);
			pending_points.push_back(r);
		end
	endfunction

	function void check_result(out_item_t got);
		out_item_t want;
		if (pending_points.size() == 0) begin
			$error("unexpected result screen_x %0d screen_y %0d", got.screen_x, got.screen_y);
			mismatch_count++;
			return;
		end
		want = pending_points.pop_front();
		if (got.screen_x !== want.screen_x) begin
			$error("screen_x expected %0d actual %0d", want.screen_x, got.screen_x);
			mismatch_count++;
		end
		if (got.screen_y !== want.screen_y) begin
			$error("screen_y expected %0d actual %0d", want.screen_y, got.screen_y);
			mismatch_count++;
		end
		if (got.visible !== want.visible) begin
			$error("visible expected %0d actual %0d", want.visible, got.visible);
			mismatch_count++;
		end
		if (got.run_start !== want.run_start) begin
			$error("run_start expected %0d actual %0d", want.run_start, got.run_start);
			mismatch_count++;
		end
		if (got.is_closure !== want.is_closure) begin
			$error("is_closure expected %0d actual %0d", want.is_closure, got.is_closure);
			mismatch_count++;
		end
		if (got.last_result !== want.last_result) begin
			$error("last_result expected %0d actual %0d", want.last_result, got.last_result);
			mismatch_count++;
		end
	endfunction
endclass

	logic                     clk;
	logic                     arst_n = 1'b0;
	logic                     cfg_wr_en = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	in_item_t                 in_data = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	out_item_t                out_data;

	projection_checker chk;

	// calm: no idling on either side; hold_off_req: receiver blocks for a long stretch
	bit calm = 1'b0;
	bit hold_off_req = 1'b0;

	coastline_point_projector_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit, far above the slowest correct run
	initial begin
		#3_000_000;
		$display("tb: failure");
		$finish;
	end

	// accepted requests feed the predictor, accepted results are checked against it
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			chk.note_request(in_data);
		if (arst_n && out_valid && !out_stall)
			chk.check_result(out_data);
	end

	// result sink: random stall, long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				hold_off_req = 1'b0;
			end
			out_stall <= !calm && ($urandom_range(99) < 9);
		end
	end

	// random value in -mag..mag at field width
	function automatic logic [15:0] spread(int mag);
		int r;
		r = int'($urandom_range(2 * mag)) - mag;
		return r[15:0];
	endfunction

	// trig register value, extremes weighted in
	function automatic logic [15:0] pick_trig();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// decimation mostly small so plenty of points are kept
	function automatic logic [7:0] pick_step();
		int r;
		r = $urandom_range(19);
		if (r < 14)
			return 8'($urandom_range(4, 1));
		if (r < 17)
			return 8'($urandom_range(30, 5));
		if (r == 17)
			return 8'd255;
		return 8'($urandom_range(255, 1));
	endfunction

	// one register write per clock; the caller lowers the enable after the batch
	task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		chk.write_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic load_settings(logic [15:0] cp, logic [15:0] sp, logic [15:0] ct,
			logic [15:0] st, bit hide, logic [7:0] step);
		write_reg(REG_COS_PHI, cp);
		write_reg(REG_SIN_PHI, sp);
		write_reg(REG_COS_THETA, ct);
		write_reg(REG_SIN_THETA, st);
		write_reg(REG_HIDE_EN, {15'd0, hide});
		write_reg(REG_DECIM_STEP, {8'd0, step});
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// offer one request and hold it until accepted
	task automatic send_request(in_item_t req);
		while (!calm && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_point(int dx, int dy, int dz, bit s, bit e);
		in_item_t req;
		req.delta_x = dx[15:0];
		req.delta_y = dy[15:0];
		req.delta_z = dz[15:0];
		req.curve_start = s;
		req.curve_end = e;
		send_request(req);
	endtask

	// well-formed curve with random walk, rarely a broken start or end or a wild delta
	task automatic send_curve(int len);
		in_item_t req;
		for (int i = 0; i < len; i++) begin
			req.curve_start = (i == 0);
			req.curve_end = (i == len - 1);
			if ($urandom_range(39) == 0)
				req.curve_start = !req.curve_start;
			if ($urandom_range(39) == 0)
				req.curve_end = !req.curve_end;
			if (i == 0) begin
				req.delta_x = spread(30000);
				req.delta_y = spread(30000);
				req.delta_z = spread(30000);
			end else if ($urandom_range(19) == 0) begin
				req.delta_x = 16'($urandom);
				req.delta_y = 16'($urandom);
				req.delta_z = 16'($urandom);
			end else begin
				req.delta_x = spread(2500);
				req.delta_y = spread(2500);
				req.delta_z = spread(2500);
			end
			send_request(req);
		end
	endtask

	// idle the input, wait out every expected result, then the dropped-point tail
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (chk.pending_points.size() != 0)
			@(posedge clk);
		repeat (32) @(posedge clk);
	endtask

	initial begin
		in_item_t req;
		int       sent;
		int       len;
		chk = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: rim (z exactly 0 is hidden), front, rim, back, front, front again
		send_point(30000, 0, 0, 1, 0);
		send_point(-30000, 0, 30000, 0, 0);
		send_point(0, 0, -30000, 0, 0);
		send_point(0, 0, -30000, 0, 0);
		send_point(0, 30000, 30000, 0, 0);
		send_point(0, 0, 0, 0, 1);
		// delta extremes and accumulator wrap
		send_point(32767, 32767, 32767, 1, 0);
		send_point(32767, -32768, -32768, 0, 0);
		send_point(-32768, -32768, -32768, 0, 1);
		settle();

		// trig extremes with hiding off: saturation, single-point curve with closure
		load_settings(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 1'b0, 8'd1);
		send_point(-32768, -32768, -32768, 1, 1);
		send_point(32767, 32767, 32767, 1, 0);
		send_point(0, 0, 0, 0, 1);
		settle();

		// decimation step zero acts as one
		load_settings(16'h7fff, 16'h0000, 16'd30048, 16'd13066, 1'b0, 8'd0);
		send_point(1000, 2000, 3000, 1, 0);
		send_point(-1, -1, -1, 0, 1);
		settle();

		// every third point; curve ends on a dropped point so only the closure comes
		load_settings(16'd23170, 16'd23170, 16'd30048, 16'hcaf6, 1'b0, 8'd3);
		send_point(20000, 10000, 5000, 1, 0);
		send_point(100, 200, 300, 0, 0);
		send_point(-100, -200, -300, 0, 0);
		send_point(500, -500, 500, 0, 0);
		send_point(7, 7, 7, 0, 1);
		settle();

		// hiding on, end on a dropped point: no result at all
		load_settings(16'h7fff, 16'h0000, 16'd30048, 16'd13066, 1'b1, 8'd2);
		send_point(0, 0, 30000, 1, 0);
		send_point(10, 10, 10, 0, 1);
		settle();

		// random phases, each with its own settings
		for (int p = 0; p < 7; p++) begin
			if (p == 0)
				load_settings(16'h7fff, 16'h0000, 16'd30048, 16'd13066, 1'b1, 8'd1);
			else if (p == 6)
				load_settings(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 1'b0, 8'd255);
			else
				load_settings(pick_trig(), pick_trig(), pick_trig(), pick_trig(),
					1'($urandom_range(1)), pick_step());
			// long stretch with no idling on either side
			calm = (p == 2);
			// receiver blocks while requests keep coming, so the block backs up
			if (p == 0)
				hold_off_req = 1'b1;
			sent = 0;
			while (sent < 110) begin
				if ($urandom_range(9) == 0) begin
					req.delta_x = 16'($urandom);
					req.delta_y = 16'($urandom);
					req.delta_z = 16'($urandom);
					req.curve_start = 1'($urandom);
					req.curve_end = 1'($urandom);
					send_request(req);
					sent++;
				end else begin
					if ($urandom_range(9) == 0 || p == 6)
						len = $urandom_range(300, 40);
					else
						len = $urandom_range(12, 1);
					send_curve(len);
					sent += len;
				end
			end
			calm = 1'b0;
			settle();
		end

		if (chk.mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
